// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL that checks itself.
// Every macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/blq_pkg.sv =====
// Package for the bounded list queue: request and status codes, defaults, cell command type.
// It depends on nothing else.
package blq_pkg;

    localparam int DEPTH_DEF = 4;
    localparam int DATA_W    = 32;

    localparam logic [1:0] MODE_PUSH   = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_INSERT = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_NOMATCH = 2'd3;

    typedef struct packed {
        logic push_go;
        logic ins_go;
    } blq_cmd_t;

endpackage

// ===== sv/bounded_list_queue_top.sv =====
// Top level of the bounded list queue: a row of blq_cell slots, the entry count and the
// result register. Uses blq_pkg, blq_cell and assert_macros.svh.
//
//   channel | valid     | stall     | beat fields
//   in      | in_valid  | in_stall  | mode, new_value, match_value
//   out     | out_valid | out_stall | status, entry_total, head_value, tail_value
//
// One beat per cycle is sustained while out is not stalled.
// The path that sets the cycle is the match compare, its ripple through the row of cells
// and the tail select over all slots.
// Reset clears the entry count and the result valid flag; slot contents and result fields
// stay unknown.
// A held result stalls in only while out_stall is high.
`include "assert_macros.svh"

module bounded_list_queue_top
    import blq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    localparam int CW   = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               mode,
    input  logic signed [DATA_W-1:0] new_value,
    input  logic signed [DATA_W-1:0] match_value,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               status,
    output logic [CW-1:0]            entry_total,
    output logic signed [DATA_W-1:0] head_value,
    output logic signed [DATA_W-1:0] tail_value
);

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [1:0]               status_reg;
    logic [1:0]               status_next;
    logic [CW-1:0]            total_reg;
    logic signed [DATA_W-1:0] head_reg;
    logic signed [DATA_W-1:0] head_next;
    logic signed [DATA_W-1:0] tail_reg;
    logic signed [DATA_W-1:0] tail_next;

    logic signed [DATA_W-1:0] cell_value [DEPTH];
    logic signed [DATA_W-1:0] cell_next  [DEPTH];
    logic                     first_chain [DEPTH+1];
    logic                     found_chain [DEPTH+1];

    logic     accept;
    logic     is_empty;
    logic     is_full;
    blq_cmd_t cmd;

    assign accept   = in_valid && !in_stall;
    assign in_stall = out_valid_reg && out_stall;
    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CW'(DEPTH));

    assign first_chain[0] = 1'b0;
    assign found_chain[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        blq_cell u_cell (
            .clk         (clk),
            .cmd         (cmd),
            .occupied    (count_reg > CW'(i)),
            .new_value   (new_value),
            .match_value (match_value),
            .prev_value  ((i == 0) ? new_value : cell_value[(i == 0) ? 0 : i - 1]),
            .first_in    (first_chain[i]),
            .found_in    (found_chain[i]),
            .value       (cell_value[i]),
            .value_next  (cell_next[i]),
            .first_out   (first_chain[i+1]),
            .found_out   (found_chain[i+1])
        );
    end

    always_comb
    begin
        cmd         = '0;
        status_next = ST_DONE;
        count_next  = count_reg;
        unique case (mode)
            MODE_PUSH:
            begin
                if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.push_go = accept;
                    count_next  = count_reg + CW'(1);
                end
            end
            MODE_REMOVE:
            begin
                if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - CW'(1);
                end
            end
            MODE_INSERT:
            begin
                priority if (is_empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (is_full)
                begin
                    status_next = ST_FULL;
                end
                else if (!found_chain[DEPTH])
                begin
                    status_next = ST_NOMATCH;
                end
                else
                begin
                    cmd.ins_go = accept;
                    count_next = count_reg + CW'(1);
                end
            end
            default:
            begin
                status_next = ST_DONE;
            end
        endcase
    end

    always_comb
    begin
        head_next = (count_next == '0) ? '0 : cell_next[0];
        tail_next = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            tail_next = tail_next | (cell_next[i] & {DATA_W{count_next == CW'(i + 1)}});
        end
    end

    always_comb
    begin
        priority if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            total_reg  <= count_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_total = total_reg;
    assign head_value  = head_reg;
    assign tail_value  = tail_reg;

    `ASSERT_IMPLY(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "Entry count exceeds depth.")
    `ASSERT_IMPLY(a_no_insert_past_end, first_chain[DEPTH], count_reg == CW'(DEPTH),
                  "A match on the last slot was seen with room left in the list.")
    `ASSERT_NEXT(a_result_follows, accept, out_valid && entry_total == count_reg,
                 "Accepted request did not produce a result with the new count.")
    `ASSERT_NEXT(a_remove_empty, accept && mode == MODE_REMOVE && count_reg == '0,
                 status == ST_EMPTY && entry_total == '0,
                 "Removal from an empty list was not refused.")

endmodule

// ===== sv/blq_cell.sv =====
// One slot of the list: holds a value, compares it with the match value and either
// shifts from its neighbor toward the head, takes the new value or keeps its own. Uses blq_pkg.
module blq_cell
    import blq_pkg::*;
(
    input  logic                     clk,
    input  blq_cmd_t                 cmd,
    input  logic                     occupied,
    input  logic signed [DATA_W-1:0] new_value,
    input  logic signed [DATA_W-1:0] match_value,
    input  logic signed [DATA_W-1:0] prev_value,
    input  logic                     first_in,
    input  logic                     found_in,
    output logic signed [DATA_W-1:0] value,
    output logic signed [DATA_W-1:0] value_next,
    output logic                     first_out,
    output logic                     found_out
);

    logic signed [DATA_W-1:0] value_reg;
    logic                     hit;

    assign hit       = occupied && (value_reg == match_value);
    assign first_out = hit && !found_in;
    assign found_out = found_in || hit;
    assign value     = value_reg;

    always_comb
    begin
        priority if (cmd.push_go)
        begin
            value_next = prev_value;
        end
        else if (cmd.ins_go && first_in)
        begin
            value_next = new_value;
        end
        else if (cmd.ins_go && found_in)
        begin
            value_next = prev_value;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// ===== tb/sv/blq_list_checker.sv =====
// Checker for the bounded list queue: watches both channels, predicts each result beat
// from its own copy of the list and compares it field by field. Depends on blq_pkg.
module blq_list_checker
    import blq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [1:0]               mode,
    input  logic signed [DATA_W-1:0] new_value,
    input  logic signed [DATA_W-1:0] match_value,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [1:0]               status,
    input  logic [CW-1:0]            entry_total,
    input  logic signed [DATA_W-1:0] head_value,
    input  logic signed [DATA_W-1:0] tail_value,
    output int                       mismatch_count,
    output int                       pending_count
);

    typedef struct packed {
        logic [1:0]               status;
        logic [CW-1:0]            total;
        logic signed [DATA_W-1:0] head;
        logic signed [DATA_W-1:0] tail;
    } list_result_t;

    logic signed [DATA_W-1:0] list_slots [DEPTH];
    int                       list_fill;
    list_result_t             expected_results [$];
    list_result_t             seen_result;
    list_result_t             due_result;

    function automatic list_result_t apply_request(
        input logic [1:0]               req_mode,
        input logic signed [DATA_W-1:0] req_new,
        input logic signed [DATA_W-1:0] req_match
    );
        list_result_t res;
        int           pos;
        bit           found;

        found      = 1'b0;
        pos        = 0;
        res.status = ST_DONE;
        case (req_mode)
            MODE_PUSH:
            begin
                if (list_fill >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = list_fill; i > 0; i--)
                        list_slots[i] = list_slots[i - 1];
                    list_slots[0] = req_new;
                    list_fill++;
                end
            end
            MODE_REMOVE:
            begin
                if (list_fill == 0)
                    res.status = ST_EMPTY;
                else
                    list_fill--;
            end
            MODE_INSERT:
            begin
                if (list_fill == 0)
                    res.status = ST_EMPTY;
                else if (list_fill >= DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    for (int i = 0; i < list_fill; i++)
                    begin
                        if (!found && list_slots[i] == req_match)
                        begin
                            found = 1'b1;
                            pos   = i;
                        end
                    end
                    if (!found)
                        res.status = ST_NOMATCH;
                    else
                    begin
                        for (int i = list_fill; i > pos + 1; i--)
                            list_slots[i] = list_slots[i - 1];
                        list_slots[pos + 1] = req_new;
                        list_fill++;
                    end
                end
            end
            default:
            begin
            end
        endcase
        res.total = CW'(list_fill);
        if (list_fill == 0)
        begin
            res.head = '0;
            res.tail = '0;
        end
        else
        begin
            res.head = list_slots[0];
            res.tail = list_slots[list_fill - 1];
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            list_fill = 0;
            expected_results.delete();
            mismatch_count = 0;
            pending_count  = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen_result = {status, entry_total, head_value, tail_value};
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result beat: status %0d total %0d head %0d tail %0d",
                                 seen_result.status, seen_result.total,
                                 seen_result.head, seen_result.tail);
                end
                else
                begin
                    due_result = expected_results.pop_front();
                    if (seen_result !== due_result)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $display("mismatch: expected status %0d total %0d head %0d tail %0d",
                                     due_result.status, due_result.total,
                                     due_result.head, due_result.tail);
                            $display("          got      status %0d total %0d head %0d tail %0d",
                                     seen_result.status, seen_result.total,
                                     seen_result.head, seen_result.tail);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(apply_request(mode, new_value, match_value));
            pending_count = expected_results.size();
        end
    end

endmodule

// ===== tb/sv/tb_bounded_list_queue_top.sv =====
// Testbench top for the bounded list queue: clock, reset, request stimulus, result stall
// and the verdict. Depends on blq_pkg, bounded_list_queue_top and blq_list_checker.
module tb_bounded_list_queue_top;
    import blq_pkg::*;

    localparam int         DEPTH           = DEPTH_DEF;
    localparam int         CW              = $clog2(DEPTH + 1);
    localparam logic [1:0] MODE_UNUSED     = 2'd3;
    localparam int         QUIET_LIMIT     = 1000;
    localparam int         ITEMS_PER_PHASE = 345;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] new_value;
    logic signed [DATA_W-1:0] match_value;
    logic                     out_valid;
    logic                     out_stall;
    logic [1:0]               status;
    logic [CW-1:0]            entry_total;
    logic signed [DATA_W-1:0] head_value;
    logic signed [DATA_W-1:0] tail_value;

    int mismatch_count;
    int pending_count;
    int send_idle_pct;
    int recv_idle_pct;
    int quiet_cycles;

    logic signed [DATA_W-1:0] value_pool [8];

    bounded_list_queue_top #(.DEPTH(DEPTH)) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .new_value   (new_value),
        .match_value (match_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .entry_total (entry_total),
        .head_value  (head_value),
        .tail_value  (tail_value)
    );

    blq_list_checker #(.DEPTH(DEPTH)) u_list_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .new_value      (new_value),
        .match_value    (match_value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .entry_total    (entry_total),
        .head_value     (head_value),
        .tail_value     (tail_value),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("bounded_list_queue_top verification failed");
                $finish;
            end
        end
    end

    task automatic send_request(
        input logic [1:0]               req_mode,
        input logic signed [DATA_W-1:0] req_new,
        input logic signed [DATA_W-1:0] req_match
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        mode        <= req_mode;
        new_value   <= req_new;
        match_value <= req_match;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Values mostly come from a small pool so that inserts find their match.
    function automatic logic signed [DATA_W-1:0] pick_value();
        if ($urandom_range(99) < 70)
            return value_pool[3'($urandom_range(7))];
        return $urandom;
    endfunction

    initial
    begin
        int         roll;
        logic [1:0] pick_mode;

        in_valid      = 1'b0;
        mode          = MODE_PUSH;
        new_value     = '0;
        match_value   = '0;
        rst_n         = 1'b0;
        quiet_cycles  = 0;
        send_idle_pct = 9;
        recv_idle_pct = 72;
        value_pool    = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sh1,
                          32'sh1, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_1234};

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        send_request(MODE_REMOVE, 32'sh0, 32'sh0);
        send_request(MODE_INSERT, 32'sh1, 32'sh0);
        send_request(MODE_UNUSED, 32'sh0, 32'sh0);
        send_request(MODE_PUSH, 32'sh8000_0000, 32'sh0);
        send_request(MODE_PUSH, 32'sh7FFF_FFFF, 32'sh0);
        send_request(MODE_PUSH, 32'sh0, 32'sh0);
        send_request(MODE_INSERT, -32'sh1, 32'sh7FFF_FFFF);
        send_request(MODE_PUSH, 32'sh1, 32'sh0);
        send_request(MODE_INSERT, 32'sh1, 32'sh0);
        send_request(MODE_UNUSED, -32'sh1, -32'sh1);
        send_request(MODE_REMOVE, 32'sh0, 32'sh0);
        send_request(MODE_INSERT, 32'sh2, 32'sh0001_2345);
        send_request(MODE_REMOVE, 32'sh0, 32'sh0);
        send_request(MODE_PUSH, 32'sh0, 32'sh0);
        send_request(MODE_INSERT, 32'sh5555_5555, 32'sh0);
        send_request(MODE_REMOVE, 32'sh0, 32'sh0);
        send_request(MODE_REMOVE, 32'sh0, 32'sh0);
        send_request(MODE_REMOVE, 32'sh0, 32'sh0);
        send_request(MODE_REMOVE, 32'sh0, 32'sh0);
        send_request(MODE_REMOVE, -32'sh1, -32'sh1);
        send_request(MODE_PUSH, 32'shAAAA_AAAA, 32'sh0);
        send_request(MODE_INSERT, 32'sh5555_5555, 32'shAAAA_AAAA);
        send_request(MODE_REMOVE, 32'sh0, 32'sh0);
        send_request(MODE_REMOVE, 32'sh0, 32'sh0);

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 9;
                    recv_idle_pct = 72;
                end
                1:
                begin
                    send_idle_pct = 72;
                    recv_idle_pct = 9;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (ITEMS_PER_PHASE)
            begin
                roll = $urandom_range(99);
                if (roll < 35)
                    pick_mode = MODE_PUSH;
                else if (roll < 65)
                    pick_mode = MODE_REMOVE;
                else if (roll < 95)
                    pick_mode = MODE_INSERT;
                else
                    pick_mode = MODE_UNUSED;
                send_request(pick_mode, pick_value(), pick_value());
            end
        end

        in_valid <= 1'b0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
        if (mismatch_count == 0)
            $display("bounded_list_queue_top verification clean");
        else
            $display("bounded_list_queue_top verification failed");
        $finish;
    end

endmodule
